/* rtl/core/aip_pkg.sv */
// Shared types, constants and helpers for the ASCII integer parser.
// No dependencies; every RTL file of the block refers to it by scoped names, the testbench imports it.
package aip_pkg;

  // Value and count widths
  localparam int VALUE_BITS  = 32;
  localparam int MAX_CHARS   = 255;
  localparam int CNT_W       = $clog2(MAX_CHARS + 1);
  localparam int BASE_W      = 6;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 8;
  localparam int OUT_DATA_W  = OUT_VALUE_W + OUT_COUNT_W;
  localparam int CHAR_W      = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  // Radix constants
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic       start;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       dig_ok;
    logic [3:0] dig_val;
  } aip_item_t;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_FIRST       = 6'b000001,
    PH_AFTER_MINUS = 6'b000010,
    PH_AFTER_ZERO  = 6'b000100,
    PH_HOLD_X      = 6'b001000,
    PH_DIGITS      = 6'b010000,
    PH_DONE        = 6'b100000
  } aip_phase_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic pop;
    logic emit;
    logic done;
  } aip_status_t;

  // Saturating character count increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    res = cnt;
    if (cnt < CNT_W'(MAX_CHARS)) begin
      res = cnt + 1'b1;
    end
    return res;
  endfunction

endpackage

/* rtl/core/aip_front.sv */
// Front end of the ASCII integer parser: accepts characters and classifies them.
// Depends on aip_pkg for the item type and character codes.
module aip_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [aip_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
  input  logic                         s_tuser,   // [0] string_start
  input  logic                         q_ready,
  output logic                         q_push,
  output aip_pkg::aip_item_t           q_item
);

  // Take a character whenever the queue has room
  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;

  // Decode the character into flags and a digit value
  always_comb begin
    q_item          = '0;
    q_item.start    = s_tuser;
    q_item.is_minus = (s_tdata == aip_pkg::CH_MINUS);
    q_item.is_zero  = (s_tdata == aip_pkg::CH_ZERO);
    q_item.is_x     = (s_tdata == aip_pkg::CH_X);
    if (s_tdata inside {[aip_pkg::CH_ZERO:aip_pkg::CH_NINE]}) begin
      q_item.dig_ok  = 1'b1;
      q_item.dig_val = 4'(s_tdata - aip_pkg::CH_ZERO);
    end else if (s_tdata inside {[aip_pkg::CH_LOW_A:aip_pkg::CH_LOW_F]}) begin
      q_item.dig_ok  = 1'b1;
      q_item.dig_val = 4'(s_tdata - aip_pkg::CH_LOW_A + 8'd10);
    end else if (s_tdata inside {[aip_pkg::CH_UP_A:aip_pkg::CH_UP_F]}) begin
      q_item.dig_ok  = 1'b1;
      q_item.dig_val = 4'(s_tdata - aip_pkg::CH_UP_A + 8'd10);
    end
  end

endmodule

/* rtl/core/aip_queue.sv */
// Short queue of classified characters between the parser front and back.
// Depends on aip_pkg for the item type and depth.
module aip_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  aip_pkg::aip_item_t  push_item,
  output logic                ready,
  input  logic                pop,
  output logic                valid,
  output aip_pkg::aip_item_t  head
);

  aip_pkg::aip_item_t             mem [aip_pkg::QUEUE_DEPTH];
  logic [aip_pkg::QPTR_W-1:0]     wr_ptr;
  logic [aip_pkg::QPTR_W-1:0]     rd_ptr;
  logic [aip_pkg::QPTR_W:0]       count;

  assign ready = (count != (aip_pkg::QPTR_W + 1)'(aip_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/aip_back.sv */
// Back end of the ASCII integer parser: parse phase, multiply-add and result register.
// Depends on aip_pkg for the item, phase and status types.
module aip_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  aip_pkg::aip_item_t                q_item,
  output logic                              q_pop,
  input  logic [aip_pkg::BASE_W-1:0]        number_base,
  input  logic                              signed_mode,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [aip_pkg::OUT_DATA_W-1:0]    m_tdata,  // [31:0] parsed_value, [39:32] chars_consumed
  output aip_pkg::aip_status_t              status
);

  aip_pkg::aip_phase_t                      phase;
  logic [aip_pkg::VALUE_BITS-1:0]           acc;
  logic [aip_pkg::BASE_W-1:0]               wbase;
  logic [aip_pkg::CNT_W-1:0]                cnt;
  logic                                     minus;

  aip_pkg::aip_phase_t                      phase_eff;
  logic [aip_pkg::VALUE_BITS-1:0]           acc_eff;
  logic [aip_pkg::BASE_W-1:0]               wbase_eff;
  logic [aip_pkg::CNT_W-1:0]                cnt_eff;
  logic                                     minus_eff;

  aip_pkg::aip_phase_t                      phase_next;
  logic [aip_pkg::VALUE_BITS-1:0]           acc_next;
  logic [aip_pkg::BASE_W-1:0]               wbase_next;
  logic [aip_pkg::CNT_W-1:0]                cnt_next;
  logic                                     minus_next;

  logic                                     advance;
  logic                                     try_digit;
  logic                                     emit;
  logic [aip_pkg::BASE_W-1:0]               base_sel;
  logic [aip_pkg::CNT_W-1:0]                cnt_base;
  logic [aip_pkg::VALUE_BITS+aip_pkg::BASE_W-1:0] prod;
  logic [aip_pkg::VALUE_BITS-1:0]           acc_mac;
  logic [aip_pkg::VALUE_BITS-1:0]           value_res;
  logic [aip_pkg::BASE_W-1:0]               auto_dec;
  logic [aip_pkg::BASE_W-1:0]               auto_oct;

  // Work on the head item whenever the result register can take a result
  assign advance = q_valid && (!m_tvalid || m_tready);
  assign q_pop   = advance;

  assign auto_dec = (number_base != '0) ? number_base : aip_pkg::BASE_DEC;
  assign auto_oct = (number_base != '0) ? number_base : aip_pkg::BASE_OCT;

  // Start flag restarts the string before this character is looked at
  always_comb begin
    if (q_item.start) begin
      phase_eff = aip_pkg::PH_FIRST;
      acc_eff   = '0;
      wbase_eff = '0;
      cnt_eff   = '0;
      minus_eff = 1'b0;
    end else begin
      phase_eff = phase;
      acc_eff   = acc;
      wbase_eff = wbase;
      cnt_eff   = cnt;
      minus_eff = minus;
    end
  end

  // Multiply-add for an accepted digit
  assign prod    = acc_eff * base_sel;
  assign acc_mac = prod[aip_pkg::VALUE_BITS-1:0]
                 + {{(aip_pkg::VALUE_BITS-4){1'b0}}, q_item.dig_val};

  // Two's complement negate when a minus was seen
  assign value_res = minus_eff ? (~acc_eff + 1'b1) : acc_eff;

  // Phase decode and digit acceptance
  always_comb begin
    phase_next = phase_eff;
    acc_next   = acc_eff;
    wbase_next = wbase_eff;
    cnt_next   = cnt_eff;
    minus_next = minus_eff;
    try_digit  = 1'b0;
    emit       = 1'b0;
    base_sel   = wbase_eff;
    cnt_base   = cnt_eff;

    case (phase_eff)
      aip_pkg::PH_FIRST,
      aip_pkg::PH_AFTER_MINUS: begin
        if ((phase_eff == aip_pkg::PH_FIRST) && signed_mode && q_item.is_minus) begin
          minus_next = 1'b1;
          cnt_next   = aip_pkg::sat_inc(cnt_eff);
          phase_next = aip_pkg::PH_AFTER_MINUS;
        end else if (q_item.is_zero) begin
          cnt_next   = aip_pkg::sat_inc(cnt_eff);
          phase_next = aip_pkg::PH_AFTER_ZERO;
        end else begin
          base_sel   = auto_dec;
          wbase_next = auto_dec;
          try_digit  = 1'b1;
        end
      end
      aip_pkg::PH_AFTER_ZERO: begin
        if (q_item.is_x) begin
          phase_next = aip_pkg::PH_HOLD_X;
        end else begin
          base_sel   = auto_oct;
          wbase_next = auto_oct;
          try_digit  = 1'b1;
        end
      end
      aip_pkg::PH_HOLD_X: begin
        // Hex digit after "0x": force base 16 and count the held 'x'
        if (q_item.dig_ok) begin
          base_sel   = aip_pkg::BASE_HEX;
          wbase_next = aip_pkg::BASE_HEX;
          cnt_base   = aip_pkg::sat_inc(cnt_eff);
          try_digit  = 1'b1;
        end else begin
          emit       = 1'b1;
          phase_next = aip_pkg::PH_DONE;
        end
      end
      aip_pkg::PH_DIGITS: begin
        try_digit = 1'b1;
      end
      default: begin
        phase_next = aip_pkg::PH_DONE;
      end
    endcase

    // Accumulate a digit below the base, otherwise end the number
    if (try_digit) begin
      if (q_item.dig_ok && ({{(aip_pkg::BASE_W-4){1'b0}}, q_item.dig_val} < base_sel)) begin
        acc_next   = acc_mac;
        cnt_next   = aip_pkg::sat_inc(cnt_base);
        phase_next = aip_pkg::PH_DIGITS;
      end else begin
        emit       = 1'b1;
        phase_next = aip_pkg::PH_DONE;
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= aip_pkg::PH_FIRST;
      acc   <= '0;
      wbase <= '0;
      cnt   <= '0;
      minus <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      acc   <= acc_next;
      wbase <= wbase_next;
      cnt   <= cnt_next;
      minus <= minus_next;
    end
  end

  // Result register: load on emit, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= {aip_pkg::OUT_COUNT_W'(cnt_eff), aip_pkg::OUT_VALUE_W'(value_res)};
    end
  end

  assign status.pop  = advance;
  assign status.emit = advance && emit;
  assign status.done = (phase == aip_pkg::PH_DONE);

endmodule

/* rtl/core/ascii_integer_parser.sv */
// ASCII integer parser: one character enters per cycle on the slave stream while
// s_tready is high, with string_start in tuser; one result per parsed number leaves
// on the master stream. Sustained rate is one character per clock cycle while the
// queue has room and m_tready does not hold the result register. A terminating
// character goes into the four-entry character queue, then through the parse stage,
// whose single 32x6 multiply-add per cycle sets the pace, into the result register.
// Configuration (number_base at index 0, signed_mode at index 1) is written through
// cfg_we/cfg_index/cfg_data. Depends on aip_pkg, aip_front, aip_queue and aip_back.
module ascii_integer_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] char_code
  input  logic                                s_tuser,   // [0] string_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [aip_pkg::OUT_DATA_W-1:0]      m_tdata,   // [31:0] parsed_value, [39:32] chars_consumed
  input  logic                                cfg_we,
  input  logic [aip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aip_pkg::BASE_W-1:0]          cfg_data
);

  logic [aip_pkg::BASE_W-1:0] number_base;
  logic                       signed_mode;

  logic                       q_ready;
  logic                       q_push;
  aip_pkg::aip_item_t         q_in;
  logic                       q_valid;
  aip_pkg::aip_item_t         q_head;
  logic                       q_pop;
  aip_pkg::aip_status_t       status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= '0;
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        aip_pkg::REG_NUMBER_BASE: number_base <= cfg_data;
        aip_pkg::REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aip_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  aip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  aip_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_head),
    .q_pop       (q_pop),
    .number_base (number_base),
    .signed_mode (signed_mode),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .status      (status)
  );

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) status.pop |-> q_valid)
    else $error("parse stage popped an empty queue");

  // A result ends the number: the phase is done right after
  assert property (@(posedge clk) disable iff (rst) status.emit |=> status.done)
    else $error("phase not done after a result");

  // A fresh result only appears after the parse stage emitted one
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !($past(m_tvalid) && !$past(m_tready))) |-> $past(status.emit))
    else $error("result appeared without an emit");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for ascii_integer_parser: streams characters, predicts each number.
// The predictor tracks the parse phase and register settings locally; needs aip_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import aip_pkg::*;

  localparam int RUN_LIMIT     = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS   = 6;
  localparam int PHASE_COUNT   = 12;
  localparam logic [4:0] NO_DIGIT = 5'h1F;

  typedef struct {
    logic [7:0] code;
    logic       start;
    bit         drain_first;
  } char_item_t;

  typedef struct {
    logic [OUT_VALUE_W-1:0] value;
    logic [OUT_COUNT_W-1:0] count;
  } number_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] char_code
  logic s_tuser = 1'b0;         // [0] string_start
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;  // [31:0] parsed_value, [39:32] chars_consumed
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUMBER_BASE;
  logic [BASE_W-1:0] cfg_data = '0;

  // Local copy of the parser state and registers
  aip_phase_t parse_at = PH_FIRST;
  logic [31:0] acc = '0;
  logic [BASE_W-1:0] wbase = '0;
  logic [7:0] used_chars = '0;
  logic minus_on = 1'b0;
  logic [BASE_W-1:0] base_reg = '0;
  logic sign_reg = 1'b0;

  char_item_t pending[$];
  number_t numbers_due[$];

  logic in_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int rcv_tick = 0;
  int rcv_mode = 0;
  int queued_chars = 0;
  int chars_seen = 0;
  int numbers_checked = 0;
  int settings_used = 0;
  int mismatches = 0;
  int cycle_count = 0;

  ascii_integer_parser dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_F) return 5'(c - CH_LOW_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(d - 10);
  endfunction

  // Advance the local parser by one character; flag a finished number
  task automatic parse_char(input logic [7:0] c, input logic start, output bit emitted,
                            output number_t num);
    logic [4:0] d;
    bit try_prefix;
    bit try_digit;
    bit close;
    emitted = 1'b0;
    num.value = '0;
    num.count = '0;
    try_prefix = 1'b0;
    try_digit = 1'b0;
    close = 1'b0;
    if (start) begin
      parse_at = PH_FIRST;
      acc = '0;
      wbase = '0;
      used_chars = '0;
      minus_on = 1'b0;
    end
    d = digit_value(c);
    case (parse_at)
      PH_FIRST: begin
        if (sign_reg && c == CH_MINUS) begin
          minus_on = 1'b1;
          if (used_chars < MAX_CHARS) used_chars = used_chars + 8'd1;
          parse_at = PH_AFTER_MINUS;
        end else begin
          try_prefix = 1'b1;
        end
      end
      PH_AFTER_MINUS: try_prefix = 1'b1;
      PH_AFTER_ZERO: begin
        if (c == CH_X) begin
          parse_at = PH_HOLD_X;
        end else begin
          wbase = (base_reg != 0) ? base_reg : BASE_OCT;
          try_digit = 1'b1;
        end
      end
      PH_HOLD_X: begin
        // a hex digit after the held x forces base 16 and consumes both
        if (d != NO_DIGIT) begin
          wbase = BASE_HEX;
          if (used_chars < MAX_CHARS) used_chars = used_chars + 8'd1;
          acc = '0;
          try_digit = 1'b1;
        end else begin
          close = 1'b1;
        end
      end
      PH_DIGITS: try_digit = 1'b1;
      default: parse_at = PH_DONE;
    endcase
    if (try_prefix) begin
      if (c == CH_ZERO) begin
        if (used_chars < MAX_CHARS) used_chars = used_chars + 8'd1;
        parse_at = PH_AFTER_ZERO;
      end else begin
        wbase = (base_reg != 0) ? base_reg : BASE_DEC;
        try_digit = 1'b1;
      end
    end
    if (try_digit) begin
      if (d != NO_DIGIT && {1'b0, d} < wbase) begin
        acc = acc * {26'd0, wbase} + {27'd0, d};
        if (used_chars < MAX_CHARS) used_chars = used_chars + 8'd1;
        parse_at = PH_DIGITS;
      end else begin
        close = 1'b1;
      end
    end
    if (close) begin
      emitted = 1'b1;
      num.value = minus_on ? (32'd0 - acc) : acc;
      num.count = used_chars;
      parse_at = PH_DONE;
    end
  endtask

  task automatic queue_char(input logic [7:0] code, input logic start, input bit hold);
    char_item_t it;
    it.code = code;
    it.start = start;
    it.drain_first = hold;
    pending.push_back(it);
    queued_chars++;
  endtask

  task automatic push_text(input string txt, input bit hold);
    for (int i = 0; i < txt.len(); i++) queue_char(txt[i], i == 0, hold && i == 0);
  endtask

  // Hex string long enough to saturate the consumed count
  task automatic push_long_hex();
    queue_char(CH_ZERO, 1'b1, 1'b0);
    queue_char(CH_X, 1'b0, 1'b0);
    repeat ($urandom_range(256, 270)) queue_char(digit_char($urandom_range(0, 15)), 1'b0, 1'b0);
    queue_char(8'h2E, 1'b0, 1'b0);
  endtask

  // One random string: mostly well-formed numbers, some raw noise
  task automatic add_number();
    int eff;
    logic st;
    bit hold;
    int pick;
    logic [7:0] term;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 6))
        queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
      return;
    end
    st = ($urandom_range(0, 14) != 0);
    hold = ($urandom_range(0, 30) == 0);
    eff = (base_reg != 0) ? base_reg : 10;
    if ($urandom_range(0, 2) == 0) begin
      queue_char(CH_MINUS, st, hold);
      st = 1'b0;
      hold = 1'b0;
    end
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      queue_char(CH_ZERO, st, hold);
      queue_char(CH_X, 1'b0, 1'b0);
      st = 1'b0;
      hold = 1'b0;
      eff = 16;
    end else if (pick == 1) begin
      queue_char(CH_ZERO, st, hold);
      st = 1'b0;
      hold = 1'b0;
      eff = (base_reg != 0) ? base_reg : 8;
    end
    if (eff > 16) eff = 16;
    repeat ($urandom_range(0, 12)) begin
      queue_char(digit_char($urandom_range(0, eff - 1)), st, hold);
      st = 1'b0;
      hold = 1'b0;
    end
    case ($urandom_range(0, 5))
      0: term = 8'h20;
      1: term = CH_X;
      2: term = CH_MINUS;
      3: term = 8'($urandom_range(128, 255));
      4: term = 8'($urandom_range(0, 255));
      default: term = (eff < 16) ? digit_char($urandom_range(eff, 15)) : 8'h47;
    endcase
    queue_char(term, st, hold);
    repeat ($urandom_range(0, 2)) queue_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic set_config(input logic [BASE_W-1:0] base, input logic sign);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUMBER_BASE;
    cfg_data <= base;
    @(negedge clk);
    cfg_index <= REG_SIGNED_MODE;
    cfg_data <= {{(BASE_W-1){1'b0}}, sign};
    @(negedge clk);
    cfg_we <= 1'b0;
    base_reg = base;
    sign_reg = sign;
    settings_used++;
  endtask

  // Wait until every character is taken and every number has come out
  task automatic settle();
    do @(posedge clk); while (pending.size() != 0 || s_tvalid);
    while (numbers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts with random gaps, holding each transfer until taken
  always @(negedge clk) begin : send
    char_item_t head;
    if (rst || (s_tvalid && !in_taken)) begin
      // hold the current transfer
    end else if (gap_left != 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (pending.size() == 0 ||
                 (pending[0].drain_first && numbers_due.size() != 0)) begin
      s_tvalid <= 1'b0;
    end else begin
      head = pending.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= head.code;
      s_tuser <= head.start;
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  end

  // Receiver: stall pattern switches among four random modes
  always @(negedge clk) begin
    if (rcv_tick % 40 == 0) rcv_mode = $urandom_range(0, 3);
    rcv_tick++;
    case (rcv_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 4) == 0);
      default: m_tready <= (rcv_tick % 4) < 2;
    endcase
  end

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin : observe
    bit emitted;
    number_t num;
    number_t want;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_char(s_tdata, s_tuser, emitted, num);
        if (emitted) numbers_due.push_back(num);
        chars_seen++;
      end
      if (m_tvalid && m_tready) begin
        if (numbers_due.size() == 0) begin
          $error("unexpected result: parsed_value %0d, chars_consumed %0d",
                 m_tdata[OUT_VALUE_W-1:0], m_tdata[OUT_DATA_W-1:OUT_VALUE_W]);
          mismatches++;
        end else begin
          want = numbers_due.pop_front();
          numbers_checked++;
          if (m_tdata[OUT_VALUE_W-1:0] !== want.value) begin
            $error("parsed_value: expected %0d, got %0d", want.value,
                   m_tdata[OUT_VALUE_W-1:0]);
            mismatches++;
          end
          if (m_tdata[OUT_DATA_W-1:OUT_VALUE_W] !== want.count) begin
            $error("chars_consumed: expected %0d, got %0d", want.count,
                   m_tdata[OUT_DATA_W-1:OUT_VALUE_W]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int goal;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          set_config(6'd0, 1'b0);
          // first character after reset counts as a string start
          queue_char(8'h37, 1'b0, 1'b0);
          queue_char(8'h2C, 1'b0, 1'b0);
          push_text("0x1F!", 1'b0);
          push_text("0xg", 1'b0);
          push_text("017:", 1'b0);
          push_text("089", 1'b0);
          push_text("4294967297;", 1'b0);
          queue_char(8'hFF, 1'b1, 1'b0);
          queue_char(8'h80, 1'b0, 1'b0);
        end
        1: begin
          set_config(6'd10, 1'b1);
          push_text("-12 ", 1'b1);
          push_text("- ", 1'b0);
          push_text("0x1 ", 1'b0);
          push_text("-0x10 ", 1'b0);
        end
        2: set_config(6'd16, 1'b0);
        3: begin
          set_config(6'd1, 1'b1);
          push_text("0010", 1'b0);
          push_text("--", 1'b0);
        end
        4: begin
          set_config(6'd36, 1'b0);
          push_text("fF.", 1'b0);
          push_text("z", 1'b0);
        end
        5: set_config(6'd8, 1'b1);
        6: begin
          // string left open across the register write: base decided now
          set_config(6'd0, 1'b1);
          queue_char(8'h37, 1'b0, 1'b0);
          queue_char(8'h20, 1'b0, 1'b0);
        end
        7: set_config(6'd2, 1'b0);
        8: set_config(6'd5, 1'b1);
        9: set_config(6'd36, 1'b1);
        default: set_config(BASE_W'($urandom_range(0, 36)), 1'($urandom_range(0, 1)));
      endcase
      goal = queued_chars + PHASE_CHARS;
      while (queued_chars < goal) add_number();
      if (p == 2) push_long_hex();
      if (p == 5) push_text("-0", 1'b0);
      settle();
    end
    $display("Sent %0d characters under %0d register settings; %0d numbers checked.",
             chars_seen, settings_used, numbers_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/aip_pkg.sv
rtl/core/aip_front.sv
rtl/core/aip_queue.sv
rtl/core/aip_back.sv
rtl/core/ascii_integer_parser.sv
tb/testbench.sv
